/* src/assert_macros.svh */
// Assertion macros used by greedy_box_suppression.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* src/gbs_pkg.sv */
// Types and constants of the greedy box suppression block.
package gbs_pkg;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 12;
    localparam int IDX_MAX   = 4095;
    localparam int AREA_W    = 32;
    localparam int OVL_W     = 17;
    localparam int ENTRY_W   = 4 * COORD_W + AREA_W;
    localparam logic [15:0] LIMIT_RESET = 16'h8000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

/* src/gbs_if.sv */
// Handshake channels for candidate boxes and suppression results.
interface gbs_box_if;
    logic                                valid;
    logic                                ready;
    logic                                first_box;
    logic signed [gbs_pkg::COORD_W-1:0]  left_edge;
    logic signed [gbs_pkg::COORD_W-1:0]  top_edge;
    logic        [gbs_pkg::COORD_W-1:0]  box_width;
    logic        [gbs_pkg::COORD_W-1:0]  box_height;

    modport source (output valid, first_box, left_edge, top_edge, box_width, box_height,
                    input ready);
    modport sink   (input valid, first_box, left_edge, top_edge, box_width, box_height,
                    output ready);
endinterface

interface gbs_res_if;
    logic                            valid;
    logic                            ready;
    logic                            kept;
    logic [gbs_pkg::IDX_W-1:0]       set_index;
    logic                            list_full;

    modport source (output valid, kept, set_index, list_full, input ready);
    modport sink   (input valid, kept, set_index, list_full, output ready);
endinterface

/* src/greedy_box_suppression.sv */
// Greedy box suppression by intersection over union against a stored kept list.
//
//  channel   dir  handshake      payload
//  i_box     in   valid/ready    first_box, left_edge, top_edge, box_width, box_height
//  o_res     out  valid/ready    kept, set_index, list_full
//  i_cfg_*   in   wr_en          overlap_limit (16 bit)
//
// After its acceptance an item takes one read of the kept-box memory per stored box,
// a drain of the compare pipeline, a step to leave the scan and the write-back; only
// then is the next item accepted. An item against an empty list skips the reads.
// Reset clears the kept count and set index, and sets the threshold to LIMIT_RESET;
// memory contents need none. A finished result waits in the output register while
// the next item is scanned; the block stalls in its write-back cycle only if that
// register is still full.
`include "assert_macros.svh"

module greedy_box_suppression #(
    parameter int MAX_KEPT  = 64,
    parameter int MAX_BOXES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    gbs_box_if.sink     i_box,
    gbs_res_if.source   o_res
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int IW = (MAX_BOXES > 4096) ? gbs_pkg::IDX_W : $clog2(MAX_BOXES);
    localparam int IDX_LIM_I = (MAX_BOXES - 1 > gbs_pkg::IDX_MAX) ? gbs_pkg::IDX_MAX
                                                                 : MAX_BOXES - 1;
    localparam logic [IW-1:0] IDX_LIM  = IW'(IDX_LIM_I);
    localparam logic [CW-1:0] KEPT_CAP = CW'(MAX_KEPT);
    localparam int EW = gbs_pkg::ENTRY_W;
    localparam int OW = gbs_pkg::OVL_W;
    localparam int PW = 2 * OW;

    function automatic logic [OW-1:0] f_overlap(input logic signed [15:0] a0,
                                                input logic        [15:0] al,
                                                input logic signed [15:0] b0,
                                                input logic        [15:0] bl);
        logic signed [17:0] lo;
        logic signed [17:0] ea;
        logic signed [17:0] eb;
        logic signed [17:0] hi;
        logic signed [17:0] diff;
        lo   = (a0 > b0) ? 18'(a0) : 18'(b0);
        ea   = 18'(a0) + $signed({2'b00, al});
        eb   = 18'(b0) + $signed({2'b00, bl});
        hi   = (ea < eb) ? ea : eb;
        diff = hi - lo;
        return (hi > lo) ? diff[OW-1:0] : '0;
    endfunction

    gbs_pkg::t_state r_state, n_state;

    logic [15:0]          r_limit;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_box_cnt;
    logic [IW-1:0]        r_idx;
    logic signed [15:0]   r_ax, r_ay;
    logic [15:0]          r_aw, r_ah;
    logic [31:0]          r_area_a;
    logic                 r_supp;
    logic [CW-1:0]        r_rd_idx;

    logic [EW-1:0]        r_mem [MAX_KEPT];
    logic [EW-1:0]        r_rd_q;
    logic                 r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [OW-1:0]        r_ovx, r_ovy;
    logic [31:0]          r_area_b1, r_area_b2;
    logic [2*OW-1:0]      r_inter2, r_inter3;
    logic [32:0]          r_uni3;
    logic [48:0]          r_prod4;
    logic [49:0]          r_lhs4;
    logic                 r_unz4;

    logic                 r_out_valid, r_out_kept, r_out_full;
    logic [IW-1:0]        r_out_idx;

    logic                 accept, issue, pipe_busy, wb_go, room, hit;
    logic [IW-1:0]        idx_now;
    logic [33:0]          uni_full;

    assign accept    = i_box.valid && i_box.ready;
    assign issue     = (r_state == gbs_pkg::ST_SCAN) && (r_rd_idx < r_count);
    assign pipe_busy = r_v0 || r_v1 || r_v2 || r_v3 || r_v4;
    assign room      = r_count < KEPT_CAP;
    assign idx_now   = i_box.first_box ? '0 : r_box_cnt;
    assign uni_full  = {2'b00, r_area_a} + {2'b00, r_area_b2} - r_inter2;
    assign hit       = r_v4 && r_unz4 && (r_lhs4 > {1'b0, r_prod4});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        wb_go       = 1'b0;
        i_box.ready = 1'b0;
        unique case (r_state)
            gbs_pkg::ST_IDLE: begin
                i_box.ready = 1'b1;
                if (i_box.valid) begin
                    n_state = gbs_pkg::ST_SCAN;
                end
            end
            gbs_pkg::ST_SCAN: begin
                if (!issue && !pipe_busy) begin
                    n_state = gbs_pkg::ST_DONE;
                end
            end
            gbs_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    wb_go   = 1'b1;
                    n_state = gbs_pkg::ST_IDLE;
                end
            end
            default: n_state = gbs_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= gbs_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_box_cnt   <= '0;
            r_rd_idx    <= '0;
            r_supp      <= 1'b0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (accept) begin
                r_rd_idx  <= '0;
                r_supp    <= 1'b0;
                r_box_cnt <= (idx_now < IDX_LIM) ? idx_now + IW'(1) : idx_now;
                if (i_box.first_box) begin
                    r_count <= '0;
                end
            end else begin
                if (issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (hit) begin
                    r_supp <= 1'b1;
                end
            end
            if (wb_go) begin
                r_out_valid <= 1'b1;
                if (!r_supp && room) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and compare pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax  <= i_box.left_edge;
            r_ay  <= i_box.top_edge;
            r_aw  <= i_box.box_width;
            r_ah  <= i_box.box_height;
            r_idx <= idx_now;
        end
        r_area_a  <= 32'(r_aw) * 32'(r_ah);
        r_ovx     <= f_overlap(r_ax, r_aw, $signed(r_rd_q[15:0]), r_rd_q[47:32]);
        r_ovy     <= f_overlap(r_ay, r_ah, $signed(r_rd_q[31:16]), r_rd_q[63:48]);
        r_area_b1 <= r_rd_q[95:64];
        r_inter2  <= PW'(r_ovx) * PW'(r_ovy);
        r_area_b2 <= r_area_b1;
        r_uni3    <= uni_full[32:0];
        r_inter3  <= r_inter2;
        r_prod4   <= 49'(r_limit) * 49'(r_uni3);
        r_lhs4    <= {r_inter3[33:0], 16'h0000};
        r_unz4    <= (r_uni3 != '0);
        if (wb_go) begin
            r_out_kept <= !r_supp && room;
            r_out_full <= !r_supp && !room;
            r_out_idx  <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_q <= r_mem[r_rd_idx[AW-1:0]];
        end
        if (wb_go && !r_supp && room) begin
            r_mem[r_count[AW-1:0]] <= {r_area_a, r_ah, r_aw, r_ay, r_ax};
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kept      = r_out_kept;
    assign o_res.list_full = r_out_full;
    assign o_res.set_index = gbs_pkg::IDX_W'(r_out_idx);

    `ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= KEPT_CAP, "kept count overflow")
    `ASSERT_IMPLY(a_rd_bound, i_clk, i_rst_n, r_state == gbs_pkg::ST_SCAN,
                  r_rd_idx <= r_count, "read index past kept count")
    `ASSERT_IMPLY(a_done_drained, i_clk, i_rst_n, r_state == gbs_pkg::ST_DONE,
                  !pipe_busy, "write-back with compare pipeline busy")
    `ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, accept,
                 r_state == gbs_pkg::ST_SCAN && r_rd_idx == '0, "scan not started")
    `ASSERT_IMPLY(a_res_excl, i_clk, i_rst_n, r_out_valid, !(r_out_kept && r_out_full),
                  "kept and list_full both set")

endmodule

/* tb/sv/greedy_box_suppression_test.sv */
// Self-checking test of greedy box suppression against a cycle-free predictor.
module greedy_box_suppression_test;

    localparam int MAX_KEPT    = 64;
    localparam int MAX_BOXES   = 4096;
    localparam int INDEX_CAP   = (MAX_BOXES - 1 < gbs_pkg::IDX_MAX) ? MAX_BOXES - 1
                                                                    : gbs_pkg::IDX_MAX;
    localparam int STALL_LIMIT = 5000;
    localparam int SCAN_CYCLES = MAX_KEPT + 16;

    typedef struct {
        logic                                first;
        logic signed [gbs_pkg::COORD_W-1:0]  left;
        logic signed [gbs_pkg::COORD_W-1:0]  top;
        logic        [gbs_pkg::COORD_W-1:0]  width;
        logic        [gbs_pkg::COORD_W-1:0]  height;
    } t_box;

    typedef struct {
        logic                      kept;
        logic [gbs_pkg::IDX_W-1:0] set_index;
        logic                      list_full;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    gbs_box_if box_ch ();
    gbs_res_if res_ch ();

    greedy_box_suppression #(
        .MAX_KEPT (MAX_KEPT),
        .MAX_BOXES(MAX_BOXES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_box        (box_ch),
        .o_res        (res_ch)
    );

    // predictor state
    t_box        kept_box [MAX_KEPT];
    logic [31:0] kept_area[MAX_KEPT];
    int          kept_n;
    logic [gbs_pkg::IDX_W-1:0] set_pos;
    logic [15:0] limit_q;

    t_verdict awaited_verdicts[$];
    int       faults;
    int       quiet_cycles;
    int       send_gap_pct;
    int       res_stall_pct;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic t_verdict predict_suppression(t_box b);
        logic [63:0] area_a;
        logic [63:0] inter;
        logic [63:0] uni;
        logic        survives;
        t_verdict    v;
        area_a   = 64'(b.width) * 64'(b.height);
        survives = 1'b1;
        if (b.first) begin
            kept_n  = 0;
            set_pos = '0;
        end
        v.set_index = set_pos;
        if (set_pos < INDEX_CAP)
            set_pos++;
        for (int j = 0; j < kept_n; j++) begin
            inter = 64'(span_overlap(longint'(b.left), longint'(b.width),
                                     longint'(kept_box[j].left), longint'(kept_box[j].width)))
                  * 64'(span_overlap(longint'(b.top), longint'(b.height),
                                     longint'(kept_box[j].top), longint'(kept_box[j].height)));
            uni = area_a + 64'(kept_area[j]) - inter;
            if (uni != 0 && (inter << 16) > 64'(limit_q) * uni)
                survives = 1'b0;
        end
        v.kept      = 1'b0;
        v.list_full = 1'b0;
        if (survives) begin
            if (kept_n < MAX_KEPT) begin
                kept_box[kept_n]  = b;
                kept_area[kept_n] = area_a[31:0];
                kept_n++;
                v.kept = 1'b1;
            end else begin
                v.list_full = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic t_box make_box(logic first, int l, int t, int w, int h);
        t_box b;
        b.first  = first;
        b.left   = 16'(l);
        b.top    = 16'(t);
        b.width  = 16'(w);
        b.height = 16'(h);
        return b;
    endfunction

    task automatic send_box(input t_box b);
        t_verdict v;
        while ($urandom_range(99) < send_gap_pct) begin
            box_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        box_ch.valid      <= 1'b1;
        box_ch.first_box  <= b.first;
        box_ch.left_edge  <= b.left;
        box_ch.top_edge   <= b.top;
        box_ch.box_width  <= b.width;
        box_ch.box_height <= b.height;
        do
            @(posedge i_clk);
        while (!box_ch.ready);
        v = predict_suppression(b);
        awaited_verdicts.insert(awaited_verdicts.size(), v);
    endtask

    task automatic drain;
        box_ch.valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_overlap_limit(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_q = value;
    endtask

    task automatic test_directed;
        // boxes before any first_box belong to the set opened by reset
        send_box(make_box(0, 0, 0, 160, 160));
        send_box(make_box(0, 0, 0, 160, 160));
        send_box(make_box(0, 160, 0, 160, 160));
        send_box(make_box(0, 1000, 1000, 0, 0));
        send_box(make_box(0, 1000, 1000, 0, 0));
        send_box(make_box(0, -32768, -32768, 65535, 65535));
        send_box(make_box(0, 32767, 32767, 65535, 65535));
        send_box(make_box(0, 32767, -32768, 1, 1));
        // either side of IoU one half, then exactly one half
        send_box(make_box(1, 0, 0, 100, 100));
        send_box(make_box(0, 34, 0, 100, 100));
        send_box(make_box(0, 0, 33, 100, 100));
        send_box(make_box(1, 0, 0, 3, 1));
        send_box(make_box(0, 1, 0, 3, 1));
        drain();
        write_overlap_limit(16'd0);
        send_box(make_box(1, 0, 0, 16, 16));
        send_box(make_box(0, 15, 15, 16, 16));
        send_box(make_box(0, 16, 0, 16, 16));
        drain();
        write_overlap_limit(16'hFFFF);
        send_box(make_box(1, -100, -100, 50, 50));
        send_box(make_box(0, -100, -100, 50, 50));
        send_box(make_box(0, -100, -100, 50, 51));
        send_box(make_box(0, -32768, 32767, 65535, 0));
        drain();
        write_overlap_limit(gbs_pkg::LIMIT_RESET);
    endtask

    task automatic test_list_full;
        for (int k = 0; k < MAX_KEPT + 6; k++)
            send_box(make_box(k == 0, k * 20, 0, 16, 16));
        send_box(make_box(0, 0, 0, 16, 16));
        send_box(make_box(1, 0, 0, 16, 16));
        drain();
    endtask

    task automatic run_random_sets(input int n_items);
        int   sent;
        int   len;
        int   r;
        int   c;
        int   n_clusters;
        int   jx;
        int   jw;
        bit   spread;
        int   cx[4];
        int   cy[4];
        int   cw[4];
        int   chh[4];
        t_box b;
        sent = 0;
        while (sent < n_items) begin
            r   = $urandom_range(99);
            len = (r < 70) ? $urandom_range(1, 12) :
                  (r < 90) ? $urandom_range(13, 40) : $urandom_range(MAX_KEPT + 1, MAX_KEPT + 26);
            spread     = (len > MAX_KEPT);
            n_clusters = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++) begin
                cx[i]  = int'($urandom_range(4000)) - 2000;
                cy[i]  = int'($urandom_range(4000)) - 2000;
                cw[i]  = $urandom_range(1, 400);
                chh[i] = $urandom_range(1, 400);
            end
            for (int k = 0; k < len && sent < n_items; k++) begin
                if ($urandom_range(99) < 12) begin
                    b.first  = 1'($urandom_range(1));
                    b.left   = 16'($urandom);
                    b.top    = 16'($urandom);
                    b.width  = 16'($urandom);
                    b.height = 16'($urandom);
                end else if (spread) begin
                    b.first  = (k == 0);
                    b.left   = 16'(int'($urandom_range(2047)) * 16 - 16384);
                    b.top    = 16'(int'($urandom_range(63)) * 16);
                    b.width  = 16'($urandom_range(1, 16));
                    b.height = 16'($urandom_range(1, 16));
                end else begin
                    b.first  = (k == 0);
                    c        = $urandom_range(n_clusters - 1);
                    jx       = cw[c] / 4 + 1;
                    jw       = chh[c] / 4 + 1;
                    b.left   = 16'(cx[c] + int'($urandom_range(2 * jx)) - jx);
                    b.top    = 16'(cy[c] + int'($urandom_range(2 * jw)) - jw);
                    b.width  = 16'(cw[c] + int'($urandom_range(2 * jx)) - jx);
                    b.height = 16'(chh[c] + int'($urandom_range(2 * jw)) - jw);
                end
                send_box(b);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [15:0] limit, input int n_items);
        write_overlap_limit(limit);
        send_gap_pct  = gap_pct;
        res_stall_pct = stall_pct;
        run_random_sets(n_items);
        drain();
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_verdicts.size() == 0) begin
                $display("%0t: unexpected result kept=%0b set_index=%0d list_full=%0b",
                         $time, res_ch.kept, res_ch.set_index, res_ch.list_full);
                faults++;
            end else begin
                exp_v = awaited_verdicts.pop_front();
                if (res_ch.kept !== exp_v.kept) begin
                    $display("%0t: kept expected %0b actual %0b",
                             $time, exp_v.kept, res_ch.kept);
                    faults++;
                end
                if (res_ch.set_index !== exp_v.set_index) begin
                    $display("%0t: set_index expected %0d actual %0d",
                             $time, exp_v.set_index, res_ch.set_index);
                    faults++;
                end
                if (res_ch.list_full !== exp_v.list_full) begin
                    $display("%0t: list_full expected %0b actual %0b",
                             $time, exp_v.list_full, res_ch.list_full);
                    faults++;
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        box_ch.valid      = 1'b0;
        box_ch.first_box  = 1'b0;
        box_ch.left_edge  = '0;
        box_ch.top_edge   = '0;
        box_ch.box_width  = '0;
        box_ch.box_height = '0;
        send_gap_pct      = 0;
        res_stall_pct     = 0;
        kept_n            = 0;
        set_pos           = '0;
        limit_q           = gbs_pkg::LIMIT_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_list_full();
        test_random_traffic(0, 0, gbs_pkg::LIMIT_RESET, 350);
        test_random_traffic(66, 0, 16'($urandom), 350);
        test_random_traffic(0, 66, 16'd19661, 350);
        test_random_traffic(21, 21, 16'd45875, 350);

        repeat (SCAN_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/gbs_pkg.sv
src/gbs_if.sv
src/greedy_box_suppression.sv
tb/sv/greedy_box_suppression_test.sv
